// File: rtl/sliding_window_maximum_defines.svh
// ----------------------------------------------------------------------------
// Sliding window maximum: assertion macros
// Shared property shorthands for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MAXIMUM_DEFINES_SVH
`define SLIDING_WINDOW_MAXIMUM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window maximum package
// Widths, default sizes and the control group that drives each cell.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

	// Field widths of the stream and configuration ports.
	localparam int SAMPLE_W       = 32;
	localparam int CFG_W          = 7;
	localparam int MAX_WINDOW_DEF = 64;

	// Per-cell control: advance on a transfer, and drive the result tap.
	typedef struct packed {
		logic shift;
		logic tap;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/swm_cell.sv
// ----------------------------------------------------------------------------
// Sliding window maximum cell
// Holds the maximum of the k most recent samples and passes it to the next
// cell, which then covers k+1 samples.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_cell
	import swm_pkg::*;
(
	input  wire logic                       clk,
	input  wire cell_ctrl_t                 ctrl,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	input  wire logic signed [SAMPLE_W-1:0] prev_max,
	output logic signed [SAMPLE_W-1:0]      max_out,
	output logic        [SAMPLE_W-1:0]      tap
);

	logic signed [SAMPLE_W-1:0] max_q;
	logic signed [SAMPLE_W-1:0] max_next;

	// New running maximum: the neighbor's span extended by the new sample.
	always_comb begin
		max_next = (prev_max > sample) ? prev_max : sample;
	end

	// Result tap, zero unless this cell covers the live horizon.
	assign tap     = ctrl.tap ? max_next : '0;
	assign max_out = max_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			max_q <= max_next;
		end
	end

endmodule

`default_nettype wire

// File: rtl/sliding_window_maximum.sv
// ----------------------------------------------------------------------------
// Sliding window maximum
// Takes one signed sample per clock and reports the largest of the last
// window_size samples of the current stream in the cycle after the transfer.
// A row of MAX_WINDOW cells holds, in cell k, the maximum of the k+1 newest
// samples; each transfer shifts the row by one cell with a compare against
// the new sample, and a one-hot tap picks the cell that matches the live
// horizon. The horizon grows by one per sample up to the window size, so a
// shrinking window drops old samples at once and a growing one does not
// bring them back. No result is given until window_size samples of the
// stream have arrived. start_of_stream (tuser) restarts the history with
// the sample it comes with. The input takes a transfer whenever the output
// register is empty or being taken, so the sustained rate is one sample per
// cycle; the limiting path is the cell compare plus the tap OR tree.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sliding_window_maximum_defines.svh"

module sliding_window_maximum
	import swm_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
)(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// Configuration write channel: window_size.
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CFG_W-1:0]    cfg_data,
	// Sample stream in.
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [SAMPLE_W-1:0] s_tdata,   // [31:0] sample
	input  wire logic [0:0]          s_tuser,   // [0] start_of_stream
	// Window maximum stream out.
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [SAMPLE_W-1:0]      m_tdata    // [31:0] window_max
);

	localparam int HW = $clog2(MAX_WINDOW + 1);
	localparam int CW = (HW > CFG_W) ? HW : CFG_W;

	logic [CFG_W-1:0]    cfg_q;
	logic [HW-1:0]       h_q;
	logic [HW-1:0]       ss_q;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_data_q;

	logic                s_xfer;
	logic                start;
	logic [CW-1:0]       cfg_ext;
	logic [HW-1:0]       w_eff;
	logic [HW:0]         h_sum;
	logic [HW:0]         ss_sum;
	logic [HW-1:0]       h_new;
	logic [HW-1:0]       ss_new;
	logic                result_ok;
	logic [SAMPLE_W-1:0] tap_or;

	logic signed [SAMPLE_W-1:0] cell_max [MAX_WINDOW];
	logic        [SAMPLE_W-1:0] cell_tap [MAX_WINDOW];
	cell_ctrl_t                 cell_ctrl [MAX_WINDOW];

	// Handshakes.
	assign cfg_ready = 1'b1;
	assign s_tready  = !out_valid_q || m_tready;
	assign s_xfer    = s_tvalid && s_tready;
	assign start     = s_tuser[0];
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	// Effective window: zero means one, larger than the row saturates.
	always_comb begin
		cfg_ext = CW'(cfg_q);
		if (cfg_q == '0) begin
			w_eff = HW'(1);
		end else if (cfg_ext > CW'(MAX_WINDOW)) begin
			w_eff = HW'(MAX_WINDOW);
		end else begin
			w_eff = HW'(cfg_ext);
		end
	end

	// Horizon and stream sample count after this transfer.
	always_comb begin
		h_sum  = (start ? '0 : {1'b0, h_q}) + (HW+1)'(1);
		ss_sum = (start ? '0 : {1'b0, ss_q}) + (HW+1)'(1);
		h_new  = (h_sum > {1'b0, w_eff}) ? w_eff : HW'(h_sum);
		ss_new = (ss_sum > (HW+1)'(MAX_WINDOW)) ? HW'(MAX_WINDOW) : HW'(ss_sum);
		result_ok = (ss_new >= w_eff);
	end

	// Row of cells; cell k reports when the horizon is k+1 samples.
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		assign cell_ctrl[i] = '{shift: s_xfer, tap: (h_new == HW'(i + 1))};

		swm_cell u_cell (
			.clk      (clk),
			.ctrl     (cell_ctrl[i]),
			.sample   ($signed(s_tdata)),
			.prev_max ((i == 0) ? $signed(s_tdata) : cell_max[(i == 0) ? 0 : i - 1]),
			.max_out  (cell_max[i]),
			.tap      (cell_tap[i])
		);
	end

	// Collect the single active tap.
	always_comb begin
		tap_or = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			tap_or = tap_or | cell_tap[i];
		end
	end

	// Configuration and stream control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= CFG_W'(1);
			h_q         <= '0;
			ss_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cfg_q <= cfg_data;
			end
			if (s_xfer) begin
				h_q         <= h_new;
				ss_q        <= ss_new;
				out_valid_q <= result_ok;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (s_xfer && result_ok) begin
			out_data_q <= tap_or;
		end
	end

	// Checks.
	`SWM_ASSERT_NOW(a_horizon_in_stream, clk, arst_n, 1'b1, h_q <= ss_q,
		"horizon beyond stream length")
	`SWM_ASSERT_NEXT(a_start_restarts, clk, arst_n, s_xfer && start,
		h_q == HW'(1) && ss_q == HW'(1), "start did not restart history")
	`SWM_ASSERT_NOW(a_no_take_when_stalled, clk, arst_n, out_valid_q && !m_tready,
		!s_tready, "sample taken over a stalled result")
	`SWM_ASSERT_NEXT(a_result_needs_fill, clk, arst_n, s_xfer && !result_ok,
		!out_valid_q, "result before window filled")

endmodule

`default_nettype wire

// File: tb/window_max_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window maximum checker
// Watches the configuration, sample and result channels of the block. Every
// accepted sample runs through a deque model of the running maximum. Each
// result the model produces is queued, and every result transfer is
// compared against the oldest queued value. The failure count and the
// number of results still due go back to the testbench top.
// ----------------------------------------------------------------------------

module window_max_checker
	import swm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [SAMPLE_W-1:0] s_tdata,   // [31:0] sample
	input  logic [0:0]          s_tuser,   // [0] start_of_stream
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [SAMPLE_W-1:0] m_tdata,   // [31:0] window_max
	output int                  error_count,
	output int                  outstanding
);

	localparam int DEPTH   = MAX_WINDOW_DEF;
	localparam int POS_MOD = 2 * MAX_WINDOW_DEF;

	// Model state: candidates with strictly decreasing values, front at 0.
	logic signed [SAMPLE_W-1:0] cand_val [DEPTH];
	int                         cand_pos [DEPTH];
	int                         cand_cnt;
	int                         next_pos;
	int                         seen;
	logic [CFG_W-1:0]           window_reg;

	// Window maxima predicted but not yet seen on the output.
	logic [SAMPLE_W-1:0] expected_max [$];

	// Window length in use: zero counts as one, oversize values saturate.
	function automatic int live_window();
		if (window_reg == '0)
			return 1;
		if (int'(window_reg) > DEPTH)
			return DEPTH;
		return int'(window_reg);
	endfunction

	// Distance from the front candidate to the incoming sample position.
	function automatic int front_age();
		return (next_pos + POS_MOD - cand_pos[0]) % POS_MOD;
	endfunction

	// Advance the deque by one sample and queue a maximum once the window is full.
	task automatic take_sample(input logic signed [SAMPLE_W-1:0] value, input logic restart);
		int w;
		w = live_window();
		if (restart) begin
			cand_cnt = 0;
			next_pos = 0;
			seen     = 0;
		end
		// Candidates that have aged out leave from the front.
		while (cand_cnt > 0 && front_age() >= w) begin
			for (int k = 0; k < cand_cnt - 1; k++) begin
				cand_val[k] = cand_val[k+1];
				cand_pos[k] = cand_pos[k+1];
			end
			cand_cnt--;
		end
		// Candidates not above the new sample leave from the back; ties keep the newest.
		while (cand_cnt > 0 && cand_val[cand_cnt-1] <= value)
			cand_cnt--;
		if (cand_cnt >= DEPTH)
			cand_cnt = DEPTH - 1;
		cand_val[cand_cnt] = value;
		cand_pos[cand_cnt] = next_pos;
		cand_cnt++;
		if (seen < DEPTH)
			seen++;
		next_pos = (next_pos + 1) % POS_MOD;
		if (seen >= w)
			expected_max.insert(expected_max.size(), cand_val[0]);
	endtask

	// Channel monitor: results are matched before the new sample is modeled.
	always @(posedge clk or negedge arst_n) begin
		logic [SAMPLE_W-1:0] want;
		if (!arst_n) begin
			window_reg  = CFG_W'(1);
			cand_cnt    = 0;
			next_pos    = 0;
			seen        = 0;
			error_count = 0;
			expected_max.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				window_reg = cfg_data;
			if (m_tvalid && m_tready) begin
				if (expected_max.size() == 0) begin
					$error("window_max: no result expected, actual %0d",
						$signed(m_tdata));
					error_count++;
				end else begin
					want = expected_max[0];
					expected_max.delete(0);
					if (m_tdata !== want) begin
						$error("window_max: expected %0d, actual %0d",
							$signed(want), $signed(m_tdata));
						error_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				take_sample(s_tdata, s_tuser[0]);
			outstanding <= expected_max.size();
		end
	end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window maximum testbench
// Drives samples and window size writes into the block, with random gaps
// on the sample and result channels, a long result hold-off that backs
// up the input, and a pause until all results are in. A short directed
// run covers the field extremes, ties, a zero window and mid-stream
// window changes. Random phases then walk through the extreme window
// sizes followed by random ones. The checker does the comparing.
// ----------------------------------------------------------------------------

module testbench;
	import swm_pkg::*;

	localparam int RANDOM_ITEMS = 1200;
	localparam int HOLD_CYCLES  = 300;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFG_W-1:0]    cfg_data;
	logic                s_tvalid;
	logic                s_tready;
	logic [SAMPLE_W-1:0] s_tdata;   // [31:0] sample
	logic [0:0]          s_tuser;   // [0] start_of_stream
	logic                m_tvalid;
	logic                m_tready;
	logic [SAMPLE_W-1:0] m_tdata;   // [31:0] window_max
	int                  error_count;
	int                  outstanding;

	// Shared pacing controls between the sample driver and the result taker.
	bit idle_on      = 1'b1;
	bit burst        = 1'b0;
	bit hold_request = 1'b0;

	sliding_window_maximum dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	window_max_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.error_count (error_count),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	// Run limit, far above the slowest legal run.
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Window sizes at the edges of the register and of the usable range.
	function automatic logic [CFG_W-1:0] edge_window(input int k);
		case (k)
			0:       return CFG_W'(0);
			1:       return CFG_W'(1);
			2:       return CFG_W'(2);
			3:       return CFG_W'(63);
			4:       return CFG_W'(64);
			5:       return CFG_W'(65);
			default: return CFG_W'(127);
		endcase
	endfunction

	// Sample values weighted toward extremes and small values that tie often.
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2, 3:    return 32'($urandom_range(0, 16)) - 32'd8;
			4:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			default: return $urandom;
		endcase
	endfunction

	// Offer one sample after a random gap and hold it until the transfer.
	task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic restart);
		int gap;
		gap = (idle_on && !burst) ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tuser  <= restart;
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop offering and wait until every predicted result has been taken.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One window size write on the configuration channel.
	task automatic write_window(input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Result taker: random stalls, plus a long hold-off when asked for.
	initial begin
		int gap;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = idle_on ? $urandom_range(0, 16) : 0;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Stimulus and verdict.
	initial begin
		int                 sent;
		int                 phase;
		int                 count;
		logic [CFG_W-1:0]   window;
		logic               restart;

		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset window of one: every sample is its own maximum.
		send_sample(32'h7FFF_FFFF, 1'b1);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'h0000_0000, 1'b0);
		send_sample(32'hFFFF_FFFF, 1'b0);
		wait_idle();

		// A zero window behaves as a window of one.
		write_window(CFG_W'(0));
		send_sample(32'd17, 1'b0);
		send_sample(32'h8000_0000, 1'b0);
		wait_idle();

		// Window of three from a fresh stream, with ties and repeated minima.
		write_window(CFG_W'(3));
		send_sample(32'd5, 1'b1);
		send_sample(32'd5, 1'b0);
		send_sample(-32'sd3, 1'b0);
		send_sample(32'd7, 1'b0);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'h8000_0000, 1'b0);
		wait_idle();

		// Shrink to two mid-stream: old candidates must leave at once.
		write_window(CFG_W'(2));
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'd9, 1'b0);
		send_sample(32'd1, 1'b0);
		wait_idle();

		// Grow to five mid-stream: evicted samples stay gone.
		write_window(CFG_W'(5));
		send_sample(32'd2, 1'b0);
		send_sample(32'h7FFF_FFFF, 1'b0);
		send_sample(32'd3, 1'b0);
		send_sample(32'd3, 1'b1);
		wait_idle();

		// Long result hold-off while samples keep coming back to back.
		write_window(CFG_W'(1));
		hold_request = 1'b1;
		burst        = 1'b1;
		for (int k = 0; k < 40; k++)
			send_sample(pick_sample(), 1'b0);
		burst = 1'b0;
		wait_idle();

		// Random phases: the extreme window sizes first, then random ones.
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			if (phase < 7)
				window = edge_window(phase);
			else if ($urandom_range(0, 3) == 0)
				window = edge_window($urandom_range(0, 6));
			else
				window = CFG_W'($urandom_range(1, 64));
			write_window(window);
			idle_on = ($urandom_range(0, 3) != 0);
			count   = $urandom_range(20, 120) + ((int'(window) > 32) ? 64 : 0);
			for (int k = 0; k < count; k++) begin
				restart = (k == 0 && $urandom_range(0, 3) != 0) ||
					($urandom_range(0, 49) == 0);
				send_sample(pick_sample(), restart);
				// Once, the sender pauses until the output has caught up.
				if (phase == 3 && k == count / 2)
					wait_idle();
			end
			sent += count;
			phase++;
			wait_idle();
		end

		idle_on = 1'b1;
		wait_idle();
		repeat (10) @(posedge clk);
		if (error_count == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/sliding_window_maximum.sv
tb/window_max_checker.sv
tb/testbench.sv
